FILE: rtl/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

	// Result kinds
	localparam logic [2:0] KIND_GEN    = 3'd0;
	localparam logic [2:0] KIND_HASH   = 3'd1;
	localparam logic [2:0] KIND_SIZE   = 3'd2;
	localparam logic [2:0] KIND_PLEN   = 3'd3;
	localparam logic [2:0] KIND_PATH   = 3'd4;
	localparam logic [2:0] KIND_ACCEPT = 3'd5;
	localparam logic [2:0] KIND_REJECT = 3'd6;

	// Reject codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNCATED = 3'd1;
	localparam logic [2:0] ERR_COUNT     = 3'd2;
	localparam logic [2:0] ERR_PATH      = 3'd3;
	localparam logic [2:0] ERR_TRAILING  = 3'd4;

	// Register map
	localparam int unsigned APB_AW = 3;
	localparam logic [APB_AW-1:0] ADDR_MAX_ENTRY = 3'd0;
	localparam logic [APB_AW-1:0] ADDR_MAX_PATH  = 3'd4;
	localparam logic [31:0] MAX_ENTRY_RESET = 32'd1024;
	localparam logic [15:0] MAX_PATH_RESET  = 16'd4096;

	// Index of the last byte of each fixed field
	localparam logic [3:0] LAST_WORD32 = 4'd3;
	localparam logic [3:0] LAST_WORD64 = 4'd7;
	localparam logic [3:0] LAST_WORD16 = 4'd1;

	typedef enum logic [6:0] {
		PH_GEN   = 7'b0000001,
		PH_COUNT = 7'b0000010,
		PH_HASH  = 7'b0000100,
		PH_SIZE  = 7'b0001000,
		PH_PLEN  = 7'b0010000,
		PH_PATH  = 7'b0100000,
		PH_DONE  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] value;
		logic [31:0] entry_index;
		logic [2:0]  error_code;
		logic        end_of_run;
	} result_t;

	// Up to two results written per accepted byte
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic result_t mk_result(logic [2:0] kind, logic [63:0] value,
			logic [31:0] idx, logic [2:0] err);
		result_t r;
		r.kind        = kind;
		r.value       = value;
		r.entry_index = idx;
		r.error_code  = err;
		r.end_of_run  = 1'b0;
		return r;
	endfunction

endpackage

FILE: rtl/sld_if.sv
`timescale 1ns / 1ps

// Byte channel
interface sld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// Result channel
interface sld_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [63:0] value;
	logic [31:0] entry_index;
	logic [2:0]  error_code;
	logic        end_of_run;

	modport source (output valid, output kind, output value, output entry_index,
		output error_code, output end_of_run, input ready);
	modport sink (input valid, input kind, input value, input entry_index,
		input error_code, input end_of_run, output ready);
endinterface

FILE: rtl/script_list_message_decoder.sv
`timescale 1ns / 1ps

// Script list message decoder.
// bytes: one message byte per word, final_byte set on the last byte of a message.
// results: tagged words (generation, hash, size, path length, path byte, accept,
//   reject), end_of_run set on the last word a byte produced.
// APB port: max_entry_count at 0x0, max_path_length at 0x4; write only while idle.
// Results: a byte's words are registered in the output buffer, behind any older words.
// Throughput: one byte per cycle while the buffer has room. A byte yields zero, one or
//   two result words; the four-word output buffer drains one word per cycle while the
//   receiver is ready, so a run of two-word bytes limits input to the output rate.
// Backpressure: bytes.ready drops when the buffer holds more than two words;
//   results wait in the buffer while the receiver stalls, nothing is lost.
// Reset: parser waits for a generation field, buffer empty, limits return to
//   1024 entries and 4096 path bytes. No clearing pass.
module script_list_message_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sld_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	sld_in_if.sink                      bytes,
	sld_out_if.source                   results
);

	logic [31:0] max_entry_q;
	logic [15:0] max_path_q;
	logic        room;
	logic        take;
	logic        wr;
	sld_pkg::push_t push;

	assign pready      = 1'b1;
	assign wr          = psel && penable && pwrite;
	assign bytes.ready = room;
	assign take        = bytes.valid && room;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entry_q <= sld_pkg::MAX_ENTRY_RESET;
			max_path_q  <= sld_pkg::MAX_PATH_RESET;
		end else if (wr) begin
			if (paddr == sld_pkg::ADDR_MAX_ENTRY) begin
				max_entry_q <= pwdata;
			end
			if (paddr == sld_pkg::ADDR_MAX_PATH) begin
				max_path_q <= pwdata[15:0];
			end
		end
	end

	// Read back
	always_comb begin
		case (paddr)
			sld_pkg::ADDR_MAX_ENTRY: prdata = max_entry_q;
			sld_pkg::ADDR_MAX_PATH:  prdata = {16'd0, max_path_q};
			default:                 prdata = 32'd0;
		endcase
	end

	sld_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.data_byte       (bytes.data_byte),
		.final_byte      (bytes.final_byte),
		.max_entry_count (max_entry_q),
		.max_path_length (max_path_q),
		.push            (push)
	);

	sld_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out    (results)
	);

endmodule

FILE: rtl/sld_parse.sv
`timescale 1ns / 1ps

// Message parser: state update and result generation for one byte per cycle while bytes are taken
module sld_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	input  logic [31:0]          max_entry_count,
	input  logic [15:0]          max_path_length,
	output sld_pkg::push_t       push
);

	sld_pkg::phase_t phase_q, phase_n;
	logic [3:0]  fbc_q, fbc_n;
	logic [63:0] shift_q, shift_n;
	logic [31:0] left_q, left_n;
	logic [15:0] plen_q, plen_n;
	logic [31:0] entry_q, entry_n;
	logic        disc_q, disc_n;

	logic [63:0] sh_in;
	logic [63:0] fval;
	logic [3:0]  flast;
	logic        rej;
	logic        mv, sv;
	sld_pkg::result_t mres, sres;

	// Field length and value for the current phase; bytes enter at the top
	always_comb begin
		sh_in = {data_byte, shift_q[63:8]};
		case (phase_q)
			sld_pkg::PH_GEN, sld_pkg::PH_COUNT: begin
				flast = sld_pkg::LAST_WORD32;
				fval  = {32'd0, sh_in[63:32]};
			end
			sld_pkg::PH_HASH, sld_pkg::PH_SIZE: begin
				flast = sld_pkg::LAST_WORD64;
				fval  = sh_in;
			end
			sld_pkg::PH_PLEN: begin
				flast = sld_pkg::LAST_WORD16;
				fval  = {48'd0, sh_in[63:48]};
			end
			default: begin
				flast = 4'd0;
				fval  = 64'd0;
			end
		endcase
	end

	// Next state and results
	always_comb begin
		phase_n = phase_q;
		fbc_n   = fbc_q;
		shift_n = shift_q;
		left_n  = left_q;
		plen_n  = plen_q;
		entry_n = entry_q;
		disc_n  = disc_q;
		rej     = 1'b0;
		mv      = 1'b0;
		sv      = 1'b0;
		mres    = sld_pkg::mk_result(sld_pkg::KIND_GEN, 64'd0, 32'd0, sld_pkg::ERR_NONE);
		sres    = mres;

		if (!disc_q) begin
			case (phase_q)
				sld_pkg::PH_PATH: begin
					mv     = 1'b1;
					mres   = sld_pkg::mk_result(sld_pkg::KIND_PATH, {56'd0, data_byte},
						entry_q, sld_pkg::ERR_NONE);
					plen_n = plen_q - 16'd1;
					if (plen_q == 16'd1) begin
						left_n  = left_q - 32'd1;
						entry_n = entry_q + 32'd1;
						phase_n = (left_q != 32'd1) ? sld_pkg::PH_HASH : sld_pkg::PH_DONE;
					end
				end
				sld_pkg::PH_DONE: begin
					mv   = 1'b1;
					rej  = 1'b1;
					mres = sld_pkg::mk_result(sld_pkg::KIND_REJECT, 64'd0, entry_q,
						sld_pkg::ERR_TRAILING);
				end
				default: begin
					shift_n = sh_in;
					fbc_n   = fbc_q + 4'd1;
					if (fbc_q == flast) begin
						shift_n = 64'd0;
						fbc_n   = 4'd0;
						case (phase_q)
							sld_pkg::PH_GEN: begin
								mv      = 1'b1;
								mres    = sld_pkg::mk_result(sld_pkg::KIND_GEN, fval, 32'd0,
									sld_pkg::ERR_NONE);
								phase_n = sld_pkg::PH_COUNT;
							end
							sld_pkg::PH_COUNT: begin
								if (fval[31:0] > max_entry_count) begin
									mv   = 1'b1;
									rej  = 1'b1;
									mres = sld_pkg::mk_result(sld_pkg::KIND_REJECT, 64'd0,
										entry_q, sld_pkg::ERR_COUNT);
								end else begin
									left_n  = fval[31:0];
									entry_n = 32'd0;
									phase_n = (fval[31:0] != 32'd0) ? sld_pkg::PH_HASH
										: sld_pkg::PH_DONE;
								end
							end
							sld_pkg::PH_HASH: begin
								mv      = 1'b1;
								mres    = sld_pkg::mk_result(sld_pkg::KIND_HASH, fval, entry_q,
									sld_pkg::ERR_NONE);
								phase_n = sld_pkg::PH_SIZE;
							end
							sld_pkg::PH_SIZE: begin
								mv      = 1'b1;
								mres    = sld_pkg::mk_result(sld_pkg::KIND_SIZE, fval, entry_q,
									sld_pkg::ERR_NONE);
								phase_n = sld_pkg::PH_PLEN;
							end
							default: begin
								mv   = 1'b1;
								mres = sld_pkg::mk_result(sld_pkg::KIND_PLEN, fval, entry_q,
									sld_pkg::ERR_NONE);
								if (fval[15:0] > max_path_length) begin
									sv   = 1'b1;
									rej  = 1'b1;
									sres = sld_pkg::mk_result(sld_pkg::KIND_REJECT, 64'd0,
										entry_q, sld_pkg::ERR_PATH);
								end else if (fval[15:0] == 16'd0) begin
									left_n  = left_q - 32'd1;
									entry_n = entry_q + 32'd1;
									phase_n = (left_q != 32'd1) ? sld_pkg::PH_HASH
										: sld_pkg::PH_DONE;
								end else begin
									plen_n  = fval[15:0];
									phase_n = sld_pkg::PH_PATH;
								end
							end
						endcase
					end
				end
			endcase

			// End of message: verdict unless already rejected
			if (final_byte && !rej) begin
				sv = 1'b1;
				if (phase_n == sld_pkg::PH_DONE) begin
					sres = sld_pkg::mk_result(sld_pkg::KIND_ACCEPT, 64'd0, entry_n,
						sld_pkg::ERR_NONE);
				end else begin
					sres = sld_pkg::mk_result(sld_pkg::KIND_REJECT, 64'd0, entry_n,
						sld_pkg::ERR_TRUNCATED);
				end
			end else if (!final_byte && rej) begin
				disc_n = 1'b1;
			end
		end

		// Final byte always restarts the message
		if (final_byte) begin
			disc_n  = 1'b0;
			phase_n = sld_pkg::PH_GEN;
			fbc_n   = 4'd0;
			shift_n = 64'd0;
			left_n  = 32'd0;
			plen_n  = 16'd0;
			entry_n = 32'd0;
		end
	end

	// Pack results in order, mark the last one
	always_comb begin
		push.first  = mv ? mres : sres;
		push.second = sres;
		push.count  = 2'd0;
		if (take) begin
			push.count = {1'b0, mv} + {1'b0, sv};
		end
		if (mv && sv) begin
			push.second.end_of_run = 1'b1;
		end else begin
			push.first.end_of_run = 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sld_pkg::PH_GEN;
			fbc_q   <= 4'd0;
			shift_q <= 64'd0;
			left_q  <= 32'd0;
			plen_q  <= 16'd0;
			entry_q <= 32'd0;
			disc_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			fbc_q   <= fbc_n;
			shift_q <= shift_n;
			left_q  <= left_n;
			plen_q  <= plen_n;
			entry_q <= entry_n;
			disc_q  <= disc_n;
		end
	end

endmodule

FILE: rtl/sld_out_fifo.sv
`timescale 1ns / 1ps

// Four-word result buffer; takes up to two words per cycle, gives one while the receiver is ready
module sld_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  sld_pkg::push_t   push,
	output logic             room,
	sld_out_if.source        out
);

	sld_pkg::result_t buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	sld_pkg::result_t head;

	// Room for two more words
	assign room = (cnt_q <= 3'd2);
	assign pop  = out.valid && out.ready;
	assign head = buf_q[rp_q];

	assign out.valid       = (cnt_q != 3'd0);
	assign out.kind        = head.kind;
	assign out.value       = head.value;
	assign out.entry_index = head.entry_index;
	assign out.error_code  = head.error_code;
	assign out.end_of_run  = head.end_of_run;

	// Storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			buf_q[wp_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			buf_q[wp_q + 2'd1] <= push.second;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push.count;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'd0, pop};
		end
	end

endmodule

FILE: tb/sld_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and APB ports, predicts the decoder's result words
// and compares them in order.
module sld_checker
	import sld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	sld_in_if                 byte_mon,
	sld_out_if                word_mon,
	output int                failures,
	output int                outstanding,
	output int                words_checked,
	output int                accepts,
	output int                rejects
);

	// Limits as last written over APB
	logic [31:0] lim_entries;
	logic [15:0] lim_path;

	// Parser state
	phase_t      phase;
	logic [3:0]  field_cnt;
	logic [63:0] field_acc;
	logic [31:0] entries_left;
	logic [15:0] path_left;
	logic [31:0] cur_entry;
	logic        discarding;

	// Words still owed by the decoder, oldest first
	result_t pending_words[$];

	task automatic report(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		failures++;
	endtask

	task automatic restart_message();
		phase        = PH_GEN;
		field_cnt    = 4'd0;
		field_acc    = 64'd0;
		entries_left = 32'd0;
		path_left    = 16'd0;
		cur_entry    = 32'd0;
	endtask

	task automatic emit(input logic [2:0] k, input logic [63:0] v, input logic [31:0] idx,
			input logic [2:0] err);
		result_t w;
		w.kind        = k;
		w.value       = v;
		w.entry_index = idx;
		w.error_code  = err;
		w.end_of_run  = 1'b0;
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic finish_entry();
		entries_left = entries_left - 32'd1;
		cur_entry    = cur_entry + 32'd1;
		phase        = (entries_left != 32'd0) ? PH_HASH : PH_DONE;
	endtask

	// Predict the words one accepted byte produces
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		int          first;
		logic        rej;
		logic [3:0]  need;
		logic [63:0] v;
		result_t     tail;
		first = pending_words.size();
		rej   = 1'b0;
		need  = 4'd0;
		v     = 64'd0;
		// after a reject, swallow bytes up to the final one
		if (discarding) begin
			if (fin) begin
				discarding = 1'b0;
				restart_message();
			end
			return;
		end
		case (phase)
		PH_PATH: begin
			emit(KIND_PATH, {56'd0, b}, cur_entry, ERR_NONE);
			path_left = path_left - 16'd1;
			if (path_left == 16'd0) begin
				finish_entry();
			end
		end
		PH_DONE: begin
			emit(KIND_REJECT, 64'd0, cur_entry, ERR_TRAILING);
			rej = 1'b1;
		end
		default: begin
			// little-endian field accumulation
			field_acc = field_acc | ({56'd0, b} << (8 * field_cnt[2:0]));
			field_cnt = field_cnt + 4'd1;
			case (phase)
			PH_GEN, PH_COUNT: need = 4'd4;
			PH_HASH, PH_SIZE: need = 4'd8;
			default:          need = 4'd2;
			endcase
			if (field_cnt >= need) begin
				v         = field_acc;
				field_acc = 64'd0;
				field_cnt = 4'd0;
				case (phase)
				PH_GEN: begin
					emit(KIND_GEN, v, 32'd0, ERR_NONE);
					phase = PH_COUNT;
				end
				PH_COUNT: begin
					// count is never emitted; over limit rejects at once
					if (v > {32'd0, lim_entries}) begin
						emit(KIND_REJECT, 64'd0, cur_entry, ERR_COUNT);
						rej = 1'b1;
					end else begin
						entries_left = v[31:0];
						cur_entry    = 32'd0;
						phase        = (entries_left != 32'd0) ? PH_HASH : PH_DONE;
					end
				end
				PH_HASH: begin
					emit(KIND_HASH, v, cur_entry, ERR_NONE);
					phase = PH_SIZE;
				end
				PH_SIZE: begin
					emit(KIND_SIZE, v, cur_entry, ERR_NONE);
					phase = PH_PLEN;
				end
				default: begin
					emit(KIND_PLEN, v, cur_entry, ERR_NONE);
					if (v[15:0] > lim_path) begin
						emit(KIND_REJECT, 64'd0, cur_entry, ERR_PATH);
						rej = 1'b1;
					end else if (v[15:0] == 16'd0) begin
						finish_entry();
					end else begin
						path_left = v[15:0];
						phase     = PH_PATH;
					end
				end
				endcase
			end
		end
		endcase
		// message end: verdict unless this byte already rejected
		if (fin) begin
			if (!rej) begin
				if (phase == PH_DONE) begin
					emit(KIND_ACCEPT, 64'd0, cur_entry, ERR_NONE);
				end else begin
					emit(KIND_REJECT, 64'd0, cur_entry, ERR_TRUNCATED);
				end
			end
			restart_message();
		end else if (rej) begin
			discarding = 1'b1;
		end
		// flag the last word of this byte
		if (pending_words.size() > first) begin
			tail = pending_words.pop_back();
			tail.end_of_run = 1'b1;
			pending_words.insert(pending_words.size(), tail);
		end
	endtask

	// Compare one delivered word with the oldest prediction
	task automatic check_word();
		result_t got;
		result_t want;
		string   diffs;
		got.kind        = word_mon.kind;
		got.value       = word_mon.value;
		got.entry_index = word_mon.entry_index;
		got.error_code  = word_mon.error_code;
		got.end_of_run  = word_mon.end_of_run;
		diffs = "";
		if (pending_words.size() == 0) begin
			report($sformatf("unexpected word kind %0d value %h", got.kind, got.value));
			return;
		end
		want = pending_words.pop_front();
		if (got.kind !== want.kind)
			diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
		if (got.value !== want.value)
			diffs = {diffs, $sformatf(" value %h/%h", got.value, want.value)};
		if (got.entry_index !== want.entry_index)
			diffs = {diffs, $sformatf(" entry %0d/%0d", got.entry_index, want.entry_index)};
		if (got.error_code !== want.error_code)
			diffs = {diffs, $sformatf(" error %0d/%0d", got.error_code, want.error_code)};
		if (got.end_of_run !== want.end_of_run)
			diffs = {diffs, $sformatf(" end %0b/%0b", got.end_of_run, want.end_of_run)};
		if (diffs != "") begin
			report($sformatf("word %0d (got/exp):%s", words_checked, diffs));
		end
		words_checked++;
		if (want.kind == KIND_ACCEPT) accepts++;
		if (want.kind == KIND_REJECT) rejects++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_entries   = MAX_ENTRY_RESET;
			lim_path      = MAX_PATH_RESET;
			discarding    = 1'b0;
			restart_message();
			pending_words.delete();
			failures      = 0;
			words_checked = 0;
			accepts       = 0;
			rejects       = 0;
			outstanding  <= 0;
		end else begin
			// register access
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr)
					ADDR_MAX_ENTRY: lim_entries = pwdata;
					ADDR_MAX_PATH:  lim_path    = pwdata[15:0];
					default: ;
					endcase
				end else begin
					case (paddr)
					ADDR_MAX_ENTRY: begin
						if (prdata !== lim_entries)
							report($sformatf("max_entry_count read %h, exp %h", prdata, lim_entries));
					end
					ADDR_MAX_PATH: begin
						if (prdata !== {16'd0, lim_path})
							report($sformatf("max_path_length read %h, exp %h", prdata, lim_path));
					end
					default: ;
					endcase
				end
			end
			// results before bytes: a byte's words never leave on its own edge
			if (word_mon.valid && word_mon.ready) begin
				check_word();
			end
			if (byte_mon.valid && byte_mon.ready) begin
				decode_byte(byte_mon.data_byte, byte_mon.final_byte);
			end
			outstanding <= pending_words.size();
		end
	end

endmodule

FILE: tb/tb_script_list_message_decoder.sv
`timescale 1ns / 1ps

module tb_script_list_message_decoder;
	import sld_pkg::*;

	typedef enum {
		MSG_GOOD,
		MSG_TRUNCATED,
		MSG_TRAILING,
		MSG_BIG_COUNT,
		MSG_BIG_PATH,
		MSG_NOISE
	} msg_mode_t;

	// Limit settings, one per random segment
	localparam logic [31:0] ENTRY_LIMITS [6] = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2,
		MAX_ENTRY_RESET};
	localparam logic [15:0] PATH_LIMITS [6] = '{16'd4, 16'hFFFF, 16'd0, 16'd2, 16'd5,
		MAX_PATH_RESET};
	localparam int SEGMENT_BYTES = 60;
	localparam int DRAIN_CAP     = 20000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int failures;
	int outstanding;
	int words_checked;
	int accepts;
	int rejects;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int messages_sent;

	// Message being assembled
	logic [7:0] msg_data[$];
	logic       msg_fin[$];

	sld_in_if  byte_ch();
	sld_out_if result_ch();

	script_list_message_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	sld_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.byte_mon      (byte_ch),
		.word_mon      (result_ch),
		.failures      (failures),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.accepts       (accepts),
		.rejects       (rejects)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result receiver with random stalls
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("timeout: decoder stopped making progress");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One APB transfer: setup, access, release
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] entry_lim, input logic [15:0] path_lim);
		apb_access(1'b1, ADDR_MAX_ENTRY, entry_lim);
		apb_access(1'b1, ADDR_MAX_PATH, {16'd0, path_lim});
		apb_access(1'b0, ADDR_MAX_ENTRY, 32'd0);
		apb_access(1'b0, ADDR_MAX_PATH, 32'd0);
	endtask

	// Present one byte; valid stays high after the handshake
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop sending and wait for every owed word, then the pipeline latency
	task automatic drain();
		int waited;
		waited = 0;
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fin);
		msg_data.insert(msg_data.size(), b);
		msg_fin.insert(msg_fin.size(), fin);
	endtask

	task automatic add_field(input logic [63:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++) begin
			add_byte(v[8*i +: 8], 1'b0);
		end
	endtask

	// Send the assembled message; its last byte always carries the final flag
	task automatic send_message();
		msg_fin[msg_fin.size() - 1] = 1'b1;
		for (int i = 0; i < msg_data.size(); i++) begin
			send_byte(msg_data[i], msg_fin[i]);
		end
		msg_data.delete();
		msg_fin.delete();
		messages_sent++;
	endtask

	// Mostly well-formed messages with random content, the rest broken or noise
	task automatic build_random_message();
		int          pick;
		int          made;
		int          plen;
		int          cut;
		logic [31:0] cnt_word;
		msg_mode_t   mode;
		pick = $urandom_range(0, 99);
		if (pick < 55)      mode = MSG_GOOD;
		else if (pick < 66) mode = MSG_TRUNCATED;
		else if (pick < 76) mode = MSG_TRAILING;
		else if (pick < 83) mode = MSG_BIG_COUNT;
		else if (pick < 91) mode = MSG_BIG_PATH;
		else                mode = MSG_NOISE;
		if (mode == MSG_NOISE) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom), $urandom_range(0, 7) == 0);
			return;
		end
		add_field({32'd0, $urandom}, 4);
		cnt_word = (mode == MSG_BIG_COUNT) ? $urandom : $urandom_range(0, 3);
		add_field({32'd0, cnt_word}, 4);
		// a huge count gets a couple of entries and then runs short
		made = (cnt_word <= 32'd3) ? int'(cnt_word) : 2;
		for (int e = 0; e < made; e++) begin
			add_field({$urandom, $urandom}, 8);
			add_field({$urandom, $urandom}, 8);
			plen = (mode == MSG_BIG_PATH && e == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 5);
			add_field(64'(plen), 2);
			repeat ((plen < 6) ? plen : 6) add_byte(8'($urandom), 1'b0);
		end
		if (mode == MSG_TRUNCATED) begin
			cut = $urandom_range(1, msg_data.size() - 1);
			repeat (cut) begin
				void'(msg_data.pop_back());
				void'(msg_fin.pop_back());
			end
		end else if (mode == MSG_TRAILING) begin
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0);
		end
	endtask

	initial begin
		int goal;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= 32'd0;
		byte_ch.valid      <= 1'b0;
		byte_ch.data_byte  <= 8'd0;
		byte_ch.final_byte <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent    = 0;
		messages_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest legal message: all-ones generation, no entries, accept
		add_field(64'hFFFF_FFFF, 4);
		add_field(64'd0, 4);
		send_message();
		// lone final byte: truncated
		add_byte(8'h00, 1'b0);
		send_message();
		// extra byte after a complete message, landing on the final byte
		add_field(64'h8040_2010, 4);
		add_field(64'd0, 4);
		add_byte(8'h5A, 1'b0);
		send_message();
		// all-ones entry count against the reset limit
		add_field(64'd0, 4);
		add_field(64'hFFFF_FFFF, 4);
		send_message();

		// random segments: three stall mixes, two limit settings each
		for (int p = 0; p < 3; p++) begin
			case (p)
			0: begin
				send_idle_pct = 29;
				recv_idle_pct = 65;
			end
			1: begin
				send_idle_pct = 65;
				recv_idle_pct = 29;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			for (int s = 0; s < 2; s++) begin
				drain();
				configure(ENTRY_LIMITS[2*p + s], PATH_LIMITS[2*p + s]);
				goal = items_sent + SEGMENT_BYTES;
				while (items_sent < goal) begin
					build_random_message();
					send_message();
				end
			end
		end
		drain();

		$display("Sent %0d bytes in %0d messages under six limit settings and three stall mixes;",
			items_sent, messages_sent);
		$display("checked %0d result words (%0d accepts, %0d rejects), %0d still owed.",
			words_checked, accepts, rejects, outstanding);
		if (failures == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
